@@ hw/rtl/pedec_pkg.sv @@
`default_nettype none

package pedec_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_HEX_HI  = 3'd2,
        MODE_HEX_LO  = 3'd3,
        MODE_MASK_HI = 3'd4,
        MODE_MASK_LO = 3'd5,
        MODE_LETTER  = 3'd6,
        MODE_HALT    = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_LONG = 2'd3
    } t_kind;

    localparam logic [8:0]  COUNT_MAX = 9'd511;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_M     = 8'h6d;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] low;
        logic [7:0] d;
        low = c | CASE_BIT;
        if (c > 8'h2f && c < 8'h3a) begin
            d = c - 8'h30;
            hex_value = {1'b0, d[3:0]};
        end else if (low > 8'h60 && low < 8'h67) begin
            d = low - 8'h57;
            hex_value = {1'b0, d[3:0]};
        end else begin
            hex_value = 5'h10;
        end
    endfunction

    // bit 8 set: unknown escape
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        case (c)
            8'h2a:   simple_escape = 9'h02a;
            8'h73:   simple_escape = 9'h020;
            8'h5c:   simple_escape = 9'h05c;
            8'h72:   simple_escape = 9'h00d;
            8'h6e:   simple_escape = 9'h00a;
            8'h74:   simple_escape = 9'h009;
            8'h30:   simple_escape = 9'h000;
            8'h62:   simple_escape = 9'h008;
            8'h61:   simple_escape = 9'h007;
            8'h71:   simple_escape = 9'h03f;
            8'h53:   simple_escape = 9'h027;
            default: simple_escape = 9'h100;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pattern_escape_decoder_unit.sv @@
// Decodes a host pattern one raw character per beat: plain characters pass, '*' becomes 0x00,
// backslash escapes (\x, \m, \i and the one-letter forms) give one byte each, and NUL, LF, CR
// or TAB end the pattern. Each result beat carries the byte, its kind (data, end, bad escape,
// too long) and the running count. After an end or error, input is dropped until a beat with
// string_start. A character is taken every cycle while o_in_stall is low; its result passes
// through the input register and the combinational parser into the result register.
// A pattern longer than MAX_RAW_LEN raw characters without a NUL ends as too long.
`default_nettype none

module pattern_escape_decoder_unit #(
    parameter int MAX_RAW_LEN = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_string_start,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_byte_out,
    output logic [1:0]      o_kind,
    output logic [8:0]      o_byte_count
);
    import pedec_pkg::*;

    localparam int              RawW   = $clog2(MAX_RAW_LEN + 1);
    localparam logic [RawW-1:0] RawMax = RawW'(MAX_RAW_LEN);

    logic         r_in_valid;
    logic [7:0]   r_char;
    logic         r_start;

    t_mode        r_mode, n_mode, c_mode;
    logic [3:0]   r_hi, n_hi, c_hi;
    logic [RawW-1:0] r_raw, n_raw, c_raw;
    logic [8:0]   r_cnt, n_cnt, c_cnt;
    logic [7:0]   r_held, n_held, c_held;
    logic         r_mask, n_mask, c_mask;

    logic         r_out_valid;
    logic [7:0]   r_byte;
    t_kind        r_kind;
    logic [8:0]   r_count;

    logic         out_free;
    logic         adv;
    logic         res_v;
    logic [7:0]   res_byte;
    t_kind        res_kind;
    logic [8:0]   res_count;
    logic         give_b;
    logic         give_e;
    t_kind        e_kind;
    logic [7:0]   b_val;
    logic [4:0]   hx;
    logic [8:0]   esc;
    logic [7:0]   lc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    assign c_mode = r_start ? MODE_NORMAL : r_mode;
    assign c_hi   = r_start ? 4'd0 : r_hi;
    assign c_raw  = r_start ? '0 : r_raw;
    assign c_cnt  = r_start ? 9'd0 : r_cnt;
    assign c_held = r_start ? 8'd0 : r_held;
    assign c_mask = r_start ? 1'b0 : r_mask;

    assign hx  = hex_value(r_char);
    assign esc = simple_escape(r_char);
    assign lc  = r_char | CASE_BIT;

    always_comb begin
        n_mode    = c_mode;
        n_hi      = c_hi;
        n_raw     = c_raw;
        n_cnt     = c_cnt;
        n_held    = c_held;
        n_mask    = c_mask;
        give_b    = 1'b0;
        give_e    = 1'b0;
        e_kind    = KIND_END;
        b_val     = 8'd0;
        res_v     = 1'b0;
        res_byte  = 8'd0;
        res_kind  = KIND_DATA;
        res_count = c_cnt;
        if (c_mode == MODE_HALT) begin
            n_mode = MODE_HALT;
        end else if (c_mode == MODE_NORMAL && c_raw >= RawMax) begin
            give_e = 1'b1;
            e_kind = (r_char == CH_NUL) ? KIND_END : KIND_LONG;
        end else begin
            if (c_raw < RawMax) begin
                n_raw = c_raw + 1'b1;
            end
            unique case (c_mode)
                MODE_NORMAL: begin
                    if (r_char == CH_NUL || r_char == CH_LF || r_char == CH_CR
                        || r_char == CH_TAB) begin
                        give_e = 1'b1;
                    end else if (r_char == CH_BSL) begin
                        n_mode = MODE_ESC;
                    end else begin
                        give_b = 1'b1;
                        b_val  = (r_char == CH_STAR) ? 8'd0 : r_char;
                    end
                end
                MODE_ESC: begin
                    if (r_char == CH_X || r_char == CH_M) begin
                        n_mask = (r_char == CH_M);
                        n_mode = MODE_HEX_HI;
                    end else if (r_char == CH_I) begin
                        n_mode = MODE_LETTER;
                    end else if (esc[8]) begin
                        give_e = 1'b1;
                        e_kind = KIND_BAD;
                    end else begin
                        n_mode = MODE_NORMAL;
                        give_b = 1'b1;
                        b_val  = esc[7:0];
                    end
                end
                MODE_HEX_HI, MODE_MASK_HI: begin
                    if (hx[4]) begin
                        give_e = 1'b1;
                        e_kind = KIND_BAD;
                    end else begin
                        n_hi   = hx[3:0];
                        n_mode = (c_mode == MODE_HEX_HI) ? MODE_HEX_LO : MODE_MASK_LO;
                    end
                end
                MODE_HEX_LO: begin
                    if (hx[4]) begin
                        give_e = 1'b1;
                        e_kind = KIND_BAD;
                    end else if (c_mask) begin
                        n_held = {c_hi, hx[3:0]};
                        n_mode = MODE_MASK_HI;
                    end else begin
                        n_mode = MODE_NORMAL;
                        give_b = 1'b1;
                        b_val  = {c_hi, hx[3:0]};
                    end
                end
                MODE_MASK_LO: begin
                    if (hx[4]) begin
                        give_e = 1'b1;
                        e_kind = KIND_BAD;
                    end else begin
                        n_mode = MODE_NORMAL;
                        n_mask = 1'b0;
                        give_b = 1'b1;
                        b_val  = c_held;
                    end
                end
                MODE_LETTER: begin
                    if (lc > 8'h7a || lc < 8'h61) begin
                        give_e = 1'b1;
                        e_kind = KIND_BAD;
                    end else begin
                        n_mode = MODE_NORMAL;
                        give_b = 1'b1;
                        b_val  = r_char;
                    end
                end
                MODE_HALT: begin
                    n_mode = MODE_HALT;
                end
            endcase
        end
        if (give_b) begin
            if (c_cnt < COUNT_MAX) begin
                n_cnt = c_cnt + 9'd1;
            end
            res_v     = 1'b1;
            res_byte  = b_val;
            res_kind  = KIND_DATA;
            res_count = n_cnt;
        end
        if (give_e) begin
            n_mode    = MODE_HALT;
            res_v     = 1'b1;
            res_byte  = 8'd0;
            res_kind  = e_kind;
            res_count = c_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_char  <= i_char_in;
            r_start <= i_string_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_hi   <= 4'd0;
            r_raw  <= '0;
            r_cnt  <= 9'd0;
            r_held <= 8'd0;
            r_mask <= 1'b0;
        end else if (adv) begin
            r_mode <= n_mode;
            r_hi   <= n_hi;
            r_raw  <= n_raw;
            r_cnt  <= n_cnt;
            r_held <= n_held;
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid && res_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_byte  <= res_byte;
            r_kind  <= res_kind;
            r_count <= res_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_out   = r_byte;
    assign o_kind       = r_kind;
    assign o_byte_count = r_count;

    a_end_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && give_e) |=> (r_mode == MODE_HALT))
        else $error("parser not halted after end beat");

    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_DATA) |-> (o_byte_count != 9'd0))
        else $error("data beat with zero count");

    a_raw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_raw <= RawMax)
        else $error("raw index past limit");

    a_escape_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_NORMAL && r_mode != MODE_HALT) |-> (r_raw != '0))
        else $error("escape state with no raw characters");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_start && r_mode == MODE_HALT) |-> !res_v)
        else $error("result while halted");

endmodule

`default_nettype wire

@@ sim/pattern_escape_decoder_unit_tb.sv @@
`timescale 1ns / 100ps

module pattern_escape_decoder_unit_tb;

    import pedec_pkg::*;

    localparam int RAW_LIMIT = 256;
    localparam int HOLD_CYCLES = 250;
    localparam logic [7:0] LETTER_LO = 8'h61;
    localparam logic [7:0] LETTER_HI = 8'h7a;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic [8:0] count;
    } decoded_t;

    typedef struct packed {
        logic [7:0] ch;
        bit         st;
        bit         known;
        decoded_t   want;
    } stim_row_t;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_char_in = 8'h00;
    logic       i_string_start = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_byte_out;
    logic [1:0] o_kind;
    logic [8:0] o_byte_count;

    decoded_t   decoded_q[$];
    logic [7:0] raw_q[$];
    int         chars_sent = 0;
    int         bad_beats = 0;
    bit         gaps_on = 1'b1;
    bit         hold_req = 1'b0;
    string      esc_set = "*s\\rnt0baqS";

    t_mode      cur_mode;
    logic [3:0] hi_nib;
    int         raw_len;
    logic [8:0] out_cnt;
    logic [7:0] held_data;
    bit         is_mask;

    stim_row_t dir_rows [28] = '{
        '{"A",     1'b1, 1'b1, '{8'h41, KIND_DATA, 9'd1}},
        '{CH_STAR, 1'b0, 1'b1, '{8'h00, KIND_DATA, 9'd2}},
        '{8'hff,   1'b0, 1'b1, '{8'hff, KIND_DATA, 9'd3}},
        '{CH_BSL,  1'b0, 1'b0, '0},
        '{CH_X,    1'b0, 1'b0, '0},
        '{"A",     1'b0, 1'b0, '0},
        '{"5",     1'b0, 1'b0, '0},
        '{CH_BSL,  1'b0, 1'b0, '0},
        '{CH_M,    1'b0, 1'b0, '0},
        '{"0",     1'b0, 1'b0, '0},
        '{"f",     1'b0, 1'b0, '0},
        '{"F",     1'b0, 1'b0, '0},
        '{"0",     1'b0, 1'b0, '0},
        '{CH_BSL,  1'b0, 1'b0, '0},
        '{CH_I,    1'b0, 1'b0, '0},
        '{"Z",     1'b0, 1'b0, '0},
        '{CH_BSL,  1'b0, 1'b0, '0},
        '{"S",     1'b0, 1'b0, '0},
        '{CH_LF,   1'b0, 1'b1, '{8'h00, KIND_END, 9'd7}},
        '{8'h80,   1'b0, 1'b0, '0},
        '{CH_NUL,  1'b1, 1'b1, '{8'h00, KIND_END, 9'd0}},
        '{CH_CR,   1'b1, 1'b1, '{8'h00, KIND_END, 9'd0}},
        '{CH_TAB,  1'b1, 1'b1, '{8'h00, KIND_END, 9'd0}},
        '{CH_BSL,  1'b1, 1'b0, '0},
        '{"k",     1'b0, 1'b1, '{8'h00, KIND_BAD, 9'd0}},
        '{CH_BSL,  1'b1, 1'b0, '0},
        '{CH_I,    1'b0, 1'b0, '0},
        '{"5",     1'b0, 1'b1, '{8'h00, KIND_BAD, 9'd0}}
    };

    pattern_escape_decoder_unit #(
        .MAX_RAW_LEN(RAW_LIMIT)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_in      (i_char_in),
        .i_string_start (i_string_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_out     (o_byte_out),
        .o_kind         (o_kind),
        .o_byte_count   (o_byte_count)
    );

    function automatic int nibble_of(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | CASE_BIT;
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (lc >= "a" && lc <= "f") return int'(lc - "a") + 10;
        return -1;
    endfunction

    function automatic int fixed_escape(input logic [7:0] c);
        case (c)
            CH_STAR: return 8'h2a;
            "s":     return 8'h20;
            CH_BSL:  return 8'h5c;
            "r":     return 8'h0d;
            "n":     return 8'h0a;
            "t":     return 8'h09;
            "0":     return 8'h00;
            "b":     return 8'h08;
            "a":     return 8'h07;
            "q":     return 8'h3f;
            "S":     return 8'h27;
            default: return -1;
        endcase
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | CASE_BIT;
        return lc >= LETTER_LO && lc <= LETTER_HI;
    endfunction

    function automatic void clear_parser();
        cur_mode = MODE_NORMAL;
        hi_nib = 4'h0;
        raw_len = 0;
        out_cnt = 9'd0;
        held_data = 8'h00;
        is_mask = 1'b0;
    endfunction

    function automatic bit close_pattern(input t_kind k, output decoded_t r);
        cur_mode = MODE_HALT;
        r.data = 8'h00;
        r.kind = k;
        r.count = out_cnt;
        return 1'b1;
    endfunction

    function automatic bit emit_byte(input logic [7:0] b, output decoded_t r);
        if (out_cnt != COUNT_MAX) out_cnt = out_cnt + 9'd1;
        r.data = b;
        r.kind = KIND_DATA;
        r.count = out_cnt;
        return 1'b1;
    endfunction

    function automatic bit decode_char(input logic [7:0] c, input bit st, output decoded_t r);
        int v;
        r = '0;
        if (st) clear_parser();
        if (cur_mode == MODE_HALT) return 1'b0;
        if (cur_mode == MODE_NORMAL && raw_len >= RAW_LIMIT)
            return close_pattern((c == CH_NUL) ? KIND_END : KIND_LONG, r);
        if (raw_len < RAW_LIMIT) raw_len++;
        case (cur_mode)
            MODE_NORMAL: begin
                if (c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_TAB)
                    return close_pattern(KIND_END, r);
                if (c == CH_BSL) begin
                    cur_mode = MODE_ESC;
                    return 1'b0;
                end
                return emit_byte((c == CH_STAR) ? 8'h00 : c, r);
            end
            MODE_ESC: begin
                if (c == CH_X || c == CH_M) begin
                    is_mask = (c == CH_M);
                    cur_mode = MODE_HEX_HI;
                    return 1'b0;
                end
                if (c == CH_I) begin
                    cur_mode = MODE_LETTER;
                    return 1'b0;
                end
                v = fixed_escape(c);
                if (v < 0) return close_pattern(KIND_BAD, r);
                cur_mode = MODE_NORMAL;
                return emit_byte(v[7:0], r);
            end
            MODE_HEX_HI, MODE_MASK_HI: begin
                v = nibble_of(c);
                if (v < 0) return close_pattern(KIND_BAD, r);
                hi_nib = v[3:0];
                cur_mode = t_mode'(cur_mode + 3'd1);
                return 1'b0;
            end
            MODE_HEX_LO: begin
                v = nibble_of(c);
                if (v < 0) return close_pattern(KIND_BAD, r);
                if (is_mask) begin
                    held_data = {hi_nib, v[3:0]};
                    cur_mode = MODE_MASK_HI;
                    return 1'b0;
                end
                cur_mode = MODE_NORMAL;
                return emit_byte({hi_nib, v[3:0]}, r);
            end
            MODE_MASK_LO: begin
                if (nibble_of(c) < 0) return close_pattern(KIND_BAD, r);
                cur_mode = MODE_NORMAL;
                is_mask = 1'b0;
                return emit_byte(held_data, r);
            end
            MODE_LETTER: begin
                if (!is_letter(c)) return close_pattern(KIND_BAD, r);
                cur_mode = MODE_NORMAL;
                return emit_byte(c, r);
            end
            default: begin
                cur_mode = MODE_HALT;
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_TAB || c == CH_BSL);
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c, input bit st, input bit known,
                             input decoded_t want);
        int gap;
        bit has;
        decoded_t got;
        gap = gaps_on ? int'($urandom_range(0, 17)) : 0;
        if (gap != 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in <= c;
        i_string_start <= st;
        do @(posedge i_clk); while (o_in_stall);
        has = decode_char(c, st, got);
        if (known) decoded_q.push_back(want);
        else if (has) decoded_q.push_back(got);
        chars_sent++;
    endtask

    task automatic flush_raw();
        foreach (raw_q[i]) send_char(raw_q[i], i == 0, 1'b0, '0);
    endtask

    task automatic add_hex(input int n, input bit broken);
        int k;
        logic [7:0] c;
        k = broken ? int'($urandom_range(0, n - 1)) : n;
        for (int i = 0; i < n; i++) begin
            if (i == k) begin
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (nibble_of(c) >= 0);
            end else begin
                c = hex_char($urandom_range(0, 15));
            end
            raw_q.push_back(c);
        end
    endtask

    task automatic add_token(input bit broken);
        logic [7:0] c;
        case ($urandom_range(0, 6))
            0: raw_q.push_back(CH_STAR);
            1, 2: raw_q.push_back(plain_char());
            3: begin
                raw_q.push_back(CH_BSL);
                raw_q.push_back(CH_X);
                add_hex(2, broken);
            end
            4: begin
                raw_q.push_back(CH_BSL);
                raw_q.push_back(CH_M);
                add_hex(4, broken);
            end
            5: begin
                raw_q.push_back(CH_BSL);
                raw_q.push_back(CH_I);
                if (broken) begin
                    do begin
                        c = 8'($urandom_range(0, 255));
                    end while (is_letter(c));
                end else begin
                    c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
                end
                raw_q.push_back(c);
            end
            default: begin
                raw_q.push_back(CH_BSL);
                if (broken) begin
                    do begin
                        c = 8'($urandom_range(0, 255));
                    end while (c == CH_X || c == CH_M || c == CH_I || fixed_escape(c) >= 0);
                end else begin
                    c = esc_set[$urandom_range(0, 10)];
                end
                raw_q.push_back(c);
            end
        endcase
    endtask

    task automatic send_pattern(input int tokens);
        raw_q.delete();
        repeat (tokens) add_token($urandom_range(0, 14) == 0);
        case ($urandom_range(0, 5))
            0: raw_q.push_back(CH_NUL);
            1: raw_q.push_back(CH_LF);
            2: raw_q.push_back(CH_CR);
            3: raw_q.push_back(CH_TAB);
            4: raw_q.push_back(CH_NUL);
            default: ;
        endcase
        repeat ($urandom_range(0, 2)) raw_q.push_back(8'($urandom_range(0, 255)));
        flush_raw();
    endtask

    // run the raw count up to the limit; optionally start an escape just before it
    task automatic send_long(input bit straddle);
        raw_q.delete();
        repeat (RAW_LIMIT - 2) raw_q.push_back(plain_char());
        if (straddle) begin
            raw_q.push_back(CH_BSL);
            raw_q.push_back(CH_X);
            add_hex(2, 1'b0);
            raw_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat (2) raw_q.push_back(plain_char());
            raw_q.push_back(CH_NUL);
        end
        flush_raw();
    endtask

    task automatic random_burst(input int target);
        while (chars_sent < target) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, '0);
            end else begin
                send_pattern($urandom_range(1, 12));
            end
        end
    endtask

    task automatic idle_until_drained();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_beat();
        decoded_t e;
        if (decoded_q.size() == 0) begin
            bad_beats++;
            if (bad_beats <= 10)
                $display("%0t: unexpected beat byte %h kind %0d count %0d",
                         $time, o_byte_out, o_kind, o_byte_count);
        end else begin
            e = decoded_q.pop_front();
            if (o_byte_out !== e.data || o_kind !== e.kind || o_byte_count !== e.count) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("%0t: got byte %h kind %0d count %0d, want byte %h kind %0d count %0d",
                             $time, o_byte_out, o_kind, o_byte_count,
                             e.data, e.kind, e.count);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("pattern_escape_decoder_unit: mismatch");
        $finish;
    end

    initial begin
        int w;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                @(negedge i_clk) i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            w = gaps_on ? int'($urandom_range(0, 17)) : 0;
            if (w != 0) begin
                @(negedge i_clk) i_out_stall <= 1'b1;
                repeat (w) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            check_beat();
        end
    end

    initial begin
        clear_parser();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[i])
            send_char(dir_rows[i].ch, dir_rows[i].st, dir_rows[i].known, dir_rows[i].want);
        random_burst(300);
        // hold the output while characters keep coming, then drain
        gaps_on = 1'b0;
        hold_req = 1'b1;
        send_pattern(24);
        idle_until_drained();
        send_long(1'b1);
        random_burst(650);
        send_long(1'b0);
        random_burst(950);
        idle_until_drained();
        repeat (20) @(posedge i_clk);
        if (bad_beats == 0 && decoded_q.size() == 0) begin
            $display("pattern_escape_decoder_unit: match");
        end else begin
            $display("pattern_escape_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
